>>> rtl/mact_pkg.sv
// shared types, constants and fixed-point helpers for the modulated allpass cascade
// with tremolo; no dependencies, used by every rtl file of the block except mact_ram
package mact_pkg;

  // default sizes of the state store
  localparam int MAX_STAGES_DEF   = 8;
  localparam int NUM_CHANNELS_DEF = 2;

  // word formats: samples q1.15, internal words q4.20, one shared multiplier
  localparam int SAMPLE_W = 16;
  localparam int WORD_W   = 24;
  localparam int OPND_W   = WORD_W + 1;
  localparam int PROD_W   = 2 * OPND_W;
  localparam int CFG_W    = 4;

  localparam int FRAC_SH = 20;
  localparam int MOD_SH  = 15;
  localparam int OUT_SH  = FRAC_SH + 5;

  localparam logic signed [OPND_W-1:0] ONE_Q20   = 25'sd1048576;
  localparam logic signed [OPND_W-1:0] BIAS_COEF = -25'sd1011876;

  localparam logic signed [PROD_W-1:0] W24_HI = 50'sd8388607;
  localparam logic signed [PROD_W-1:0] W24_LO = -50'sd8388608;
  localparam logic signed [PROD_W-1:0] S16_HI = 50'sd32767;
  localparam logic signed [PROD_W-1:0] S16_LO = -50'sd32768;

  // configuration port
  localparam int              PADDR_W           = 3;
  localparam int              PDATA_W           = 32;
  localparam logic [0:0]      REG_ACTIVE_STAGES = 1'b0;
  localparam logic [CFG_W-1:0] ACTIVE_RESET     = 4'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BIAS,
    ST_COEF,
    ST_COEF_ADD,
    ST_FWD,
    ST_Y,
    ST_BACK,
    ST_WB,
    ST_OUT_MUL,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MUL_BIAS,
    MUL_COEF,
    MUL_FWD,
    MUL_BACK,
    MUL_GAIN,
    MUL_OUT
  } mul_sel_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     ld_in;
    logic     ld_bias;
    logic     ld_m;
    logic     ld_y;
    logic     ld_g;
    logic     wb;
    logic     ld_out;
    logic     st_vld;
  } ctl_t;

  // round to nearest, ties up: add half then arithmetic shift
  function automatic logic signed [PROD_W-1:0] rnd_shr(input logic signed [PROD_W-1:0] v,
                                                       input int unsigned sh);
    logic signed [PROD_W-1:0] t;
    t = v + (PROD_W'(1) << (sh - 1));
    return t >>> sh;
  endfunction

  function automatic logic signed [PROD_W-1:0] sext_prod(input logic signed [OPND_W-1:0] v);
    return {{(PROD_W-OPND_W){v[OPND_W-1]}}, v};
  endfunction

  function automatic logic signed [WORD_W-1:0] sat24(input logic signed [PROD_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > W24_HI) r = W24_HI[WORD_W-1:0];
    else if (v < W24_LO) r = W24_LO[WORD_W-1:0];
    else r = v[WORD_W-1:0];
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > S16_HI) r = S16_HI[SAMPLE_W-1:0];
    else if (v < S16_LO) r = S16_LO[SAMPLE_W-1:0];
    else r = v[SAMPLE_W-1:0];
    return r;
  endfunction

endpackage

>>> rtl/mact_ram.sv
// generic single-port synchronous ram, registered read (read-first)
// no dependencies
module mact_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/mact_dp.sv
// datapath: shared 25x25 multiplier with product register, rounding, saturation
// and the coefficient, gain and stage registers; depends on mact_pkg
module mact_dp (
  input  logic                                  clk,
  input  mact_pkg::ctl_t                        ctl,
  input  logic signed [mact_pkg::SAMPLE_W-1:0]  in_sample_in,
  input  logic signed [mact_pkg::SAMPLE_W-1:0]  in_mod_value,
  input  logic        [mact_pkg::SAMPLE_W-1:0]  in_depth,
  input  logic        [mact_pkg::WORD_W-1:0]    ram_rdata,
  output logic        [mact_pkg::WORD_W-1:0]    ram_wdata,
  output logic signed [mact_pkg::SAMPLE_W-1:0]  out_sample_out
);

  logic signed [mact_pkg::WORD_W-1:0]   x_r;
  logic signed [mact_pkg::SAMPLE_W-1:0] mod_r;
  logic        [mact_pkg::SAMPLE_W-1:0] dep_r;
  logic signed [mact_pkg::PROD_W-1:0]   prod_r;
  logic signed [mact_pkg::WORD_W-1:0]   bias_r;
  logic signed [mact_pkg::WORD_W-1:0]   m_r;
  logic signed [mact_pkg::WORD_W-1:0]   y_r;
  logic signed [mact_pkg::WORD_W-1:0]   g_r;
  logic signed [mact_pkg::SAMPLE_W-1:0] out_r;

  logic signed [mact_pkg::OPND_W-1:0] half_w;
  logic signed [mact_pkg::OPND_W-1:0] quarter_w;
  logic signed [mact_pkg::OPND_W-1:0] one_m_half;
  logic signed [mact_pkg::OPND_W-1:0] mod_w;
  logic signed [mact_pkg::OPND_W-1:0] opa;
  logic signed [mact_pkg::OPND_W-1:0] opb;
  logic signed [mact_pkg::WORD_W-1:0] st_w;
  logic signed [mact_pkg::PROD_W-1:0] rnd_frac;
  logic signed [mact_pkg::PROD_W-1:0] rnd_mod;

  // depth/2 and depth/4 in q20
  assign half_w     = $signed({5'b0, dep_r, 4'b0});
  assign quarter_w  = $signed({6'b0, dep_r, 3'b0});
  assign one_m_half = mact_pkg::ONE_Q20 - half_w;
  assign mod_w      = {{(mact_pkg::OPND_W-mact_pkg::SAMPLE_W){mod_r[mact_pkg::SAMPLE_W-1]}},
                       mod_r};

  always_comb begin
    case (ctl.mul_sel)
      mact_pkg::MUL_BIAS: begin
        opa = one_m_half;
        opb = mact_pkg::BIAS_COEF;
      end
      mact_pkg::MUL_COEF: begin
        opa = mod_w;
        opb = half_w;
      end
      mact_pkg::MUL_FWD: begin
        opa = {m_r[mact_pkg::WORD_W-1], m_r};
        opb = {x_r[mact_pkg::WORD_W-1], x_r};
      end
      mact_pkg::MUL_BACK: begin
        opa = {m_r[mact_pkg::WORD_W-1], m_r};
        opb = {y_r[mact_pkg::WORD_W-1], y_r};
      end
      mact_pkg::MUL_GAIN: begin
        opa = mod_w;
        opb = quarter_w;
      end
      mact_pkg::MUL_OUT: begin
        opa = {x_r[mact_pkg::WORD_W-1], x_r};
        opb = {g_r[mact_pkg::WORD_W-1], g_r};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign rnd_frac = mact_pkg::rnd_shr(prod_r, mact_pkg::FRAC_SH);
  assign rnd_mod  = mact_pkg::rnd_shr(prod_r, mact_pkg::MOD_SH);

  // entries never written read as zero
  assign st_w = ctl.st_vld ? $signed(ram_rdata) : '0;

  // new stage state: x - m*y
  assign ram_wdata = mact_pkg::sat24(
      mact_pkg::sext_prod({x_r[mact_pkg::WORD_W-1], x_r}) - rnd_frac);

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
    if (ctl.ld_in) begin
      x_r   <= {{3{in_sample_in[mact_pkg::SAMPLE_W-1]}}, in_sample_in, 5'b0};
      mod_r <= in_mod_value;
      dep_r <= in_depth;
    end
    if (ctl.ld_bias) begin
      bias_r <= mact_pkg::sat24(rnd_frac);
    end
    if (ctl.ld_m) begin
      m_r <= mact_pkg::sat24(rnd_mod +
                             mact_pkg::sext_prod({bias_r[mact_pkg::WORD_W-1], bias_r}));
    end
    if (ctl.ld_y) begin
      y_r <= mact_pkg::sat24(mact_pkg::sext_prod({st_w[mact_pkg::WORD_W-1], st_w}) +
                             rnd_frac);
    end
    if (ctl.ld_g) begin
      g_r <= mact_pkg::sat24(rnd_mod + mact_pkg::sext_prod(one_m_half));
    end
    if (ctl.wb) begin
      x_r <= y_r;
    end
    if (ctl.ld_out) begin
      out_r <= mact_pkg::sat16(mact_pkg::rnd_shr(prod_r, mact_pkg::OUT_SH));
    end
  end

  assign out_sample_out = out_r;

endmodule

>>> rtl/mact_ctrl.sv
// sequencer: handshakes, stage counter, state-store addressing and valid bits
// depends on mact_pkg; drives mact_dp through ctl_t and the state ram directly
module mact_ctrl #(
  parameter int MAX_STAGES   = mact_pkg::MAX_STAGES_DEF,
  parameter int NUM_CHANNELS = mact_pkg::NUM_CHANNELS_DEF,
  localparam int DEPTH  = NUM_CHANNELS * MAX_STAGES,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int STG_W  = $clog2(MAX_STAGES + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_channel,
  input  logic [mact_pkg::CFG_W-1:0] active_stages,
  output logic                       out_valid,
  input  logic                       out_stall,
  output mact_pkg::ctl_t             ctl,
  output logic                       ram_we,
  output logic [ADDR_W-1:0]          ram_addr
);

  mact_pkg::state_t state_r, state_nxt;
  logic [STG_W-1:0] k_r, k_nxt;
  logic [STG_W-1:0] n_eff;
  logic             ch_r, ch_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [DEPTH-1:0] vld_r;
  logic             rd_vld_r;
  logic             accept;
  logic             last_stage;
  logic             out_free;

  always_comb begin
    if (active_stages == '0) begin
      n_eff = STG_W'(1);
    end else if (int'(active_stages) > MAX_STAGES) begin
      n_eff = STG_W'(MAX_STAGES);
    end else begin
      n_eff = STG_W'(active_stages);
    end
  end

  assign accept     = in_valid && !in_stall;
  assign last_stage = (k_r == n_eff - STG_W'(1));
  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != mact_pkg::ST_IDLE);
  assign out_valid  = out_valid_r;
  assign ram_addr   = ADDR_W'((ch_r ? MAX_STAGES : 0) + int'(k_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mact_pkg::ST_IDLE:     if (accept) state_nxt = mact_pkg::ST_BIAS;
      mact_pkg::ST_BIAS:     state_nxt = mact_pkg::ST_COEF;
      mact_pkg::ST_COEF:     state_nxt = mact_pkg::ST_COEF_ADD;
      mact_pkg::ST_COEF_ADD: state_nxt = mact_pkg::ST_FWD;
      mact_pkg::ST_FWD:      state_nxt = mact_pkg::ST_Y;
      mact_pkg::ST_Y:        state_nxt = mact_pkg::ST_BACK;
      mact_pkg::ST_BACK:     state_nxt = mact_pkg::ST_WB;
      mact_pkg::ST_WB: begin
        state_nxt = last_stage ? mact_pkg::ST_OUT_MUL : mact_pkg::ST_FWD;
      end
      mact_pkg::ST_OUT_MUL:  state_nxt = mact_pkg::ST_DONE;
      mact_pkg::ST_DONE:     if (out_free) state_nxt = mact_pkg::ST_IDLE;
      default:               state_nxt = mact_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl         = '0;
    ctl.mul_sel = mact_pkg::MUL_FWD;
    ctl.st_vld  = rd_vld_r;
    ram_we      = 1'b0;
    k_nxt       = k_r;
    ch_nxt      = ch_r;
    unique case (state_r)
      mact_pkg::ST_IDLE: begin
        if (accept) begin
          ctl.ld_in = 1'b1;
          k_nxt     = '0;
          ch_nxt    = (NUM_CHANNELS > 1) ? in_channel : 1'b0;
        end
      end
      mact_pkg::ST_BIAS: ctl.mul_sel = mact_pkg::MUL_BIAS;
      mact_pkg::ST_COEF: begin
        ctl.mul_sel = mact_pkg::MUL_COEF;
        ctl.ld_bias = 1'b1;
      end
      mact_pkg::ST_COEF_ADD: ctl.ld_m = 1'b1;
      mact_pkg::ST_FWD:      ctl.mul_sel = mact_pkg::MUL_FWD;
      mact_pkg::ST_Y: begin
        // state word read in the previous cycle is on the ram output now
        ctl.ld_y    = 1'b1;
        ctl.mul_sel = mact_pkg::MUL_GAIN;
      end
      mact_pkg::ST_BACK: begin
        ctl.mul_sel = mact_pkg::MUL_BACK;
        ctl.ld_g    = 1'b1;
      end
      mact_pkg::ST_WB: begin
        ctl.wb = 1'b1;
        ram_we = 1'b1;
        if (!last_stage) begin
          k_nxt = k_r + STG_W'(1);
        end
      end
      mact_pkg::ST_OUT_MUL: ctl.mul_sel = mact_pkg::MUL_OUT;
      mact_pkg::ST_DONE: begin
        // keep the output product steady while the result register is blocked
        ctl.mul_sel = mact_pkg::MUL_OUT;
        ctl.ld_out  = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.ld_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mact_pkg::ST_IDLE;
      k_r         <= '0;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= vld_r[ram_addr];
      if (ram_we) begin
        vld_r[ram_addr] <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/modulated_allpass_cascade_tremolo_unit.sv
// modulated first-order allpass cascade with tremolo gain, one result per sample
// active stages are clamped to 1..MAX_STAGES; in_stall holds off new samples until the result is
// registered, so one sample is in flight at a time; one shared multiplier, each stage needs two products
// the stage states live in a single-port ram read and rewritten once per stage
// reset: synchronous, active low; states read as zero through per-entry valid bits, active_stages = 4
module modulated_allpass_cascade_tremolo_unit #(
  parameter int MAX_STAGES   = mact_pkg::MAX_STAGES_DEF,
  parameter int NUM_CHANNELS = mact_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_channel,
  input  logic signed [mact_pkg::SAMPLE_W-1:0]  in_sample_in,
  input  logic signed [mact_pkg::SAMPLE_W-1:0]  in_mod_value,
  input  logic        [mact_pkg::SAMPLE_W-1:0]  in_depth,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [mact_pkg::SAMPLE_W-1:0]  out_sample_out,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic        [mact_pkg::PADDR_W-1:0]   paddr,
  input  logic        [mact_pkg::PDATA_W-1:0]   pwdata,
  output logic        [mact_pkg::PDATA_W-1:0]   prdata,
  output logic                                  pready
);

  localparam int DEPTH  = NUM_CHANNELS * MAX_STAGES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [mact_pkg::CFG_W-1:0] active_stages_r;
  logic [mact_pkg::CFG_W-1:0] active_stages_nxt;
  logic                       reg_sel;
  mact_pkg::ctl_t             ctl;
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_addr;
  logic [mact_pkg::WORD_W-1:0] ram_wdata;
  logic [mact_pkg::WORD_W-1:0] ram_rdata;

  // register file: one register, word addressed
  assign pready  = 1'b1;
  assign reg_sel = (paddr[mact_pkg::PADDR_W-1:2] == mact_pkg::REG_ACTIVE_STAGES);
  assign prdata  = reg_sel ? mact_pkg::PDATA_W'(active_stages_r) : '0;

  always_comb begin
    active_stages_nxt = active_stages_r;
    if (psel && penable && pwrite && pready && reg_sel) begin
      active_stages_nxt = pwdata[mact_pkg::CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_stages_r <= mact_pkg::ACTIVE_RESET;
    end else begin
      active_stages_r <= active_stages_nxt;
    end
  end

  mact_ctrl #(
    .MAX_STAGES   (MAX_STAGES),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_channel    (in_channel),
    .active_stages (active_stages_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .ctl           (ctl),
    .ram_we        (ram_we),
    .ram_addr      (ram_addr)
  );

  mact_dp u_dp (
    .clk            (clk),
    .ctl            (ctl),
    .in_sample_in   (in_sample_in),
    .in_mod_value   (in_mod_value),
    .in_depth       (in_depth),
    .ram_rdata      (ram_rdata),
    .ram_wdata      (ram_wdata),
    .out_sample_out (out_sample_out)
  );

  mact_ram #(
    .WIDTH (mact_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

>>> tb/tb_modulated_allpass_cascade_tremolo_unit.sv
// self-checking testbench for the modulated allpass cascade with tremolo: directed table,
// then random phases across stage settings, checked against a q4.20 predictor in this file
// depends on rtl/mact_pkg.sv and rtl/modulated_allpass_cascade_tremolo_unit.sv
module tb_modulated_allpass_cascade_tremolo_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mact_pkg::*;

  localparam int           N_STAGES    = MAX_STAGES_DEF;
  localparam int           N_CHANNELS  = NUM_CHANNELS_DEF;
  localparam longint       Q20_ONE     = 64'sd1048576;
  localparam longint       ROTOR_BIAS  = -64'sd1011876;
  localparam longint       WORD_MAX    = 64'sd8388607;
  localparam longint       WORD_MIN    = -64'sd8388608;
  localparam logic [PADDR_W-1:0] STAGES_ADDR = '0;
  localparam int           PHASES      = 8;
  localparam int           PHASE_ITEMS = 92;
  localparam int           LONG_HOLD   = 250;
  localparam int           DRAIN_WAIT  = 4 * N_STAGES + 10;

  typedef struct packed {
    logic        ch;
    logic [15:0] smp;
    logic [15:0] mod;
    logic [15:0] dep;
    logic        pinned;
    logic [15:0] want;
  } row_t;

  // zero samples from cleared states give zero out, whatever the coefficient
  localparam row_t DIRECTED [16] = '{
    '{1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000},
    '{1'b1, 16'h0000, 16'h8000, 16'hFFFF, 1'b1, 16'h0000},
    '{1'b0, 16'h0000, 16'h7FFF, 16'h8000, 1'b1, 16'h0000},
    '{1'b0, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0, 16'h0000},
    '{1'b0, 16'h8000, 16'h8000, 16'h8000, 1'b0, 16'h0000},
    '{1'b1, 16'h8000, 16'h7FFF, 16'h0000, 1'b0, 16'h0000},
    '{1'b1, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b0, 16'h0000},
    '{1'b0, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0, 16'h0000},
    '{1'b0, 16'h8000, 16'h8000, 16'hFFFF, 1'b0, 16'h0000},
    '{1'b0, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, 16'h0000},
    '{1'b1, 16'h0001, 16'h0001, 16'h0001, 1'b0, 16'h0000},
    '{1'b1, 16'hFFFF, 16'hFFFF, 16'h8000, 1'b0, 16'h0000},
    '{1'b0, 16'h5555, 16'h2AAA, 16'hAAAA, 1'b0, 16'h0000},
    '{1'b1, 16'hAAAA, 16'h5555, 16'h5555, 1'b0, 16'h0000},
    '{1'b0, 16'h3039, 16'hB1E0, 16'h4000, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000}
  };

  localparam logic [3:0] PHASE_STAGES [PHASES] = '{
    4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd6, 4'd8, 4'd5
  };

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_channel;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic signed [SAMPLE_W-1:0] in_mod_value;
  logic        [SAMPLE_W-1:0] in_depth;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic        [PADDR_W-1:0]  paddr;
  logic        [PDATA_W-1:0]  pwdata;
  logic        [PDATA_W-1:0]  prdata;
  logic                       pready;

  // predictor copy of the block's state and register
  logic signed [WORD_W-1:0] tap_state [N_CHANNELS][N_STAGES];
  logic        [CFG_W-1:0]  stages_mirror;
  logic signed [15:0]       sample_q [$];

  bit          pinned_on  = 1'b0;
  logic [15:0] pinned_val = '0;
  bit          gaps_on    = 1'b1;
  bit          stall_on   = 1'b1;
  bit          hold_req   = 1'b0;
  int          mismatches = 0;

  modulated_allpass_cascade_tremolo_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_channel     (in_channel),
    .in_sample_in   (in_sample_in),
    .in_mod_value   (in_mod_value),
    .in_depth       (in_depth),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint rnd_floor(input longint v, input int unsigned sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // runs one sample through the cascade and the tremolo gain, updating the stage states
  function automatic logic signed [15:0] cascade_predict(input logic ch,
                                                         input logic signed [15:0] smp,
                                                         input logic signed [15:0] mod,
                                                         input logic [15:0] dep);
    longint x, mv, dv, half, quarter, bias, coef, gain, y, s;
    int     n;
    mv      = mod;
    dv      = dep;
    x       = smp;
    x       = x * 32;
    half    = dv * 16;
    quarter = dv * 8;
    n       = stages_mirror;
    if (n < 1) n = 1;
    if (n > N_STAGES) n = N_STAGES;
    bias = clip(rnd_floor((Q20_ONE - half) * ROTOR_BIAS, 20), WORD_MIN, WORD_MAX);
    coef = clip(rnd_floor(mv * half, 15) + bias, WORD_MIN, WORD_MAX);
    for (int k = 0; k < n; k++) begin
      s = tap_state[ch][k];
      y = clip(s + rnd_floor(coef * x, 20), WORD_MIN, WORD_MAX);
      tap_state[ch][k] = WORD_W'(clip(x - rnd_floor(coef * y, 20), WORD_MIN, WORD_MAX));
      x = y;
    end
    gain = clip(rnd_floor(mv * quarter, 15) + Q20_ONE - half, WORD_MIN, WORD_MAX);
    return 16'(clip(rnd_floor(x * gain, 25), -64'sd32768, 64'sd32767));
  endfunction

  // register mirror, updated on register writes, and expected samples, taken at each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      stages_mirror = ACTIVE_RESET;
      for (int c = 0; c < N_CHANNELS; c++)
        for (int k = 0; k < N_STAGES; k++)
          tap_state[c][k] = '0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == STAGES_ADDR)
        stages_mirror = pwdata[CFG_W-1:0];
      if (in_valid && !in_stall) begin
        pinned_val = pinned_on ? pinned_val
                               : cascade_predict(in_channel, in_sample_in, in_mod_value,
                                                 in_depth);
        if (pinned_on)
          void'(cascade_predict(in_channel, in_sample_in, in_mod_value, in_depth));
        sample_q.push_back(pinned_val);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (sample_q.size() == 0) begin
        $error("sample_out: unexpected transaction, got %0d", out_sample_out);
        mismatches++;
      end else begin
        logic signed [15:0] want;
        want = sample_q.pop_front();
        if (out_sample_out !== want) begin
          $error("sample_out mismatch: expected %0d, got %0d", want, out_sample_out);
          mismatches++;
        end
      end
    end
  end

  // receiver: random stall bursts, plus one long hold counted here
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        out_stall = 1'b0;
        hold_req  = 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  task automatic reg_access(input bit wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_stages(input logic [3:0] value);
    logic [PDATA_W-1:0] rd;
    reg_access(1'b1, STAGES_ADDR, PDATA_W'(value), rd);
    reg_access(1'b0, STAGES_ADDR, '0, rd);
    if (rd !== PDATA_W'(value)) begin
      $error("active_stages readback mismatch: expected %0d, got %0d", value, rd);
      mismatches++;
    end
  endtask

  // sender goes quiet first so the last transaction is not offered again
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sample_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // valid stays high from one transaction to the next unless a gap is drawn
  task automatic offer_sample(input logic ch, input logic [15:0] smp, input logic [15:0] mod,
                              input logic [15:0] dep, input bit pin, input logic [15:0] want);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_channel   = ch;
    in_sample_in = smp;
    in_mod_value = mod;
    in_depth     = dep;
    pinned_on    = pin;
    pinned_val   = want;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic offer_random();
    logic [15:0] smp, mod, dep;
    int          kind;
    kind = $urandom_range(0, 9);
    smp  = 16'($urandom);
    mod  = 16'($urandom);
    dep  = 16'($urandom_range(0, 32768));
    if (kind inside {[6:7]}) begin
      smp = 16'($urandom_range(0, 511) - 256);
    end else if (kind == 8) begin
      dep = 16'($urandom);
    end else if (kind == 9) begin
      smp = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      mod = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      dep = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'hFFFF;
    end
    offer_sample(1'($urandom_range(0, 1)), smp, mod, dep, 1'b0, '0);
  endtask

  initial begin
    logic [PDATA_W-1:0] rd;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_channel   = 1'b0;
    in_sample_in = '0;
    in_mod_value = '0;
    in_depth     = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    reg_access(1'b0, STAGES_ADDR, '0, rd);
    if (rd !== PDATA_W'(ACTIVE_RESET)) begin
      $error("active_stages after reset: expected %0d, got %0d", ACTIVE_RESET, rd);
      mismatches++;
    end

    foreach (DIRECTED[i])
      offer_sample(DIRECTED[i].ch, DIRECTED[i].smp, DIRECTED[i].mod, DIRECTED[i].dep,
                   DIRECTED[i].pinned, DIRECTED[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      in_valid  = 1'b0;
      pinned_on = 1'b0;
      set_stages(ph == 5 ? 4'($urandom_range(0, 15)) : PHASE_STAGES[ph]);
      // alternate busy and quiet stretches, the last phase runs with no idling
      gaps_on  = (ph != PHASES - 1) && (ph != 4);
      stall_on = (ph != PHASES - 1) && (ph != 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == 30)
          hold_req = 1'b1;
        if (ph == 3 && i == 40) begin
          wait_drained();
          in_valid = 1'b0;
        end
        offer_random();
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (sample_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("** modulated_allpass_cascade_tremolo_unit: PASSED **");
    else
      $display("** modulated_allpass_cascade_tremolo_unit: FAILED **");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** modulated_allpass_cascade_tremolo_unit: FAILED **");
    $finish;
  end

endmodule
